[sv/lsf_pkg.sv]
package lsf_pkg;

    localparam int DefMaxSamples = 1024;
    localparam int DefSampleBits = 16;
    localparam int InW           = 16;
    localparam int OutW          = 48;
    localparam int FracBits      = 16;

    localparam logic [1:0] StOk      = 2'd0;
    localparam logic [1:0] StZeroDen = 2'd1;
    localparam logic [1:0] StTooMany = 2'd2;
    localparam logic [1:0] StSat     = 2'd3;

    typedef struct packed {
        logic signed [InW-1:0] x_value;
        logic signed [InW-1:0] y_value;
        logic                  last;
    } t_in_word;

    typedef struct packed {
        logic signed [OutW-1:0] slope;
        logic signed [OutW-1:0] intercept;
        logic [1:0]             status;
    } t_out_word;

    function automatic int cnt_w(input int max_samples);
        return $clog2(max_samples + 1);
    endfunction

    function automatic int sum_w(input int max_samples, input int sample_bits);
        return sample_bits + cnt_w(max_samples);
    endfunction

    function automatic int sq_w(input int max_samples, input int sample_bits);
        return 2 * sample_bits + cnt_w(max_samples);
    endfunction

    function automatic int rec_w(input int max_samples, input int sample_bits);
        return 1 + cnt_w(max_samples) + 2 * sum_w(max_samples, sample_bits)
            + 2 * sq_w(max_samples, sample_bits);
    endfunction

endpackage

[sv/lsf_front.sv]
module lsf_front #(
    parameter int MAX_SAMPLES = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  lsf_pkg::t_in_word    i_word,
    output logic                 o_q_valid,
    input  logic                 i_q_ready,
    output logic [lsf_pkg::rec_w(MAX_SAMPLES, SAMPLE_BITS)-1:0] o_rec
);
    import lsf_pkg::*;

    localparam int CW  = cnt_w(MAX_SAMPLES);
    localparam int SW  = sum_w(MAX_SAMPLES, SAMPLE_BITS);
    localparam int QW  = sq_w(MAX_SAMPLES, SAMPLE_BITS);
    localparam int PBW = 2 * SAMPLE_BITS;

    logic                          r_s1_vld;
    logic                          r_s1_last;
    logic signed [SAMPLE_BITS-1:0] r_s1_x;
    logic signed [SAMPLE_BITS-1:0] r_s1_y;
    logic signed [PBW-1:0]         r_s1_xx;
    logic signed [PBW-1:0]         r_s1_xy;

    logic signed [SAMPLE_BITS-1:0] x_s;
    logic signed [SAMPLE_BITS-1:0] y_s;
    logic signed [PBW-1:0]         xx_p;
    logic signed [PBW-1:0]         xy_p;

    logic [CW-1:0]        r_cnt, n_cnt;
    logic signed [SW-1:0] r_sx, n_sx, r_sy, n_sy;
    logic signed [QW-1:0] r_sxx, n_sxx, r_sxy, n_sxy;
    logic                 r_ovf, n_ovf;
    logic                 full;
    logic                 s1_go;

    assign x_s  = $signed(i_word.x_value[SAMPLE_BITS-1:0]);
    assign y_s  = $signed(i_word.y_value[SAMPLE_BITS-1:0]);
    assign xx_p = x_s * x_s;
    assign xy_p = x_s * y_s;

    assign s1_go   = r_s1_vld && (!r_s1_last || i_q_ready);
    assign o_ready = !r_s1_vld || s1_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (o_ready) begin
            r_s1_vld <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_s1_x    <= x_s;
            r_s1_y    <= y_s;
            r_s1_xx   <= xx_p;
            r_s1_xy   <= xy_p;
            r_s1_last <= i_word.last;
        end
    end

    always_comb begin
        full  = r_cnt >= CW'(MAX_SAMPLES);
        n_ovf = r_ovf | full;
        if (full) begin
            n_cnt = r_cnt;
            n_sx  = r_sx;
            n_sy  = r_sy;
            n_sxx = r_sxx;
            n_sxy = r_sxy;
        end else begin
            n_cnt = r_cnt + CW'(1);
            n_sx  = r_sx + SW'(r_s1_x);
            n_sy  = r_sy + SW'(r_s1_y);
            n_sxx = r_sxx + QW'(r_s1_xx);
            n_sxy = r_sxy + QW'(r_s1_xy);
        end
    end

    assign o_q_valid = s1_go && r_s1_last;
    assign o_rec     = {n_ovf, n_cnt, n_sx, n_sy, n_sxx, n_sxy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_sx  <= '0;
            r_sy  <= '0;
            r_sxx <= '0;
            r_sxy <= '0;
            r_ovf <= 1'b0;
        end else if (s1_go) begin
            if (r_s1_last) begin
                r_cnt <= '0;
                r_sx  <= '0;
                r_sy  <= '0;
                r_sxx <= '0;
                r_sxy <= '0;
                r_ovf <= 1'b0;
            end else begin
                r_cnt <= n_cnt;
                r_sx  <= n_sx;
                r_sy  <= n_sy;
                r_sxx <= n_sxx;
                r_sxy <= n_sxy;
                r_ovf <= n_ovf;
            end
        end
    end

endmodule

[sv/lsf_queue.sv]
module lsf_queue #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [W-1:0] i_data,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [W-1:0] o_data
);
    localparam int DEPTH = 2;
    localparam int AW    = $clog2(DEPTH);

    logic [W-1:0] r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic          push, pop;

    assign o_ready = r_cnt != (AW+1)'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + AW'(1);
            end
            if (pop) begin
                r_rp <= r_rp + AW'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + (AW+1)'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - (AW+1)'(1);
            end
        end
        if (push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

[sv/lsf_back.sv]
module lsf_back #(
    parameter int MAX_SAMPLES = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    output logic               o_q_ready,
    input  logic [lsf_pkg::rec_w(MAX_SAMPLES, SAMPLE_BITS)-1:0] i_rec,
    output logic               o_valid,
    input  logic               i_ready,
    output lsf_pkg::t_out_word o_word
);
    import lsf_pkg::*;

    localparam int CW = cnt_w(MAX_SAMPLES);
    localparam int SW = sum_w(MAX_SAMPLES, SAMPLE_BITS);
    localparam int QW = sq_w(MAX_SAMPLES, SAMPLE_BITS);
    localparam int MW = QW;
    localparam int PW = 2 * MW;
    localparam int NW = PW + 1;
    localparam int DW = NW + FracBits;
    localparam int KW = $clog2(DW + 1);

    localparam logic [2:0] OpNSxx  = 3'd0;
    localparam logic [2:0] OpSxSx  = 3'd1;
    localparam logic [2:0] OpNSxy  = 3'd2;
    localparam logic [2:0] OpSxSy  = 3'd3;
    localparam logic [2:0] OpSySxx = 3'd4;
    localparam logic [2:0] OpSxSxy = 3'd5;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MLD  = 7'b0000010,
        S_MUL  = 7'b0000100,
        S_MACC = 7'b0001000,
        S_DLD  = 7'b0010000,
        S_DIV  = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    t_state r_state;
    logic   r_dfin;

    logic                 rec_ovf;
    logic [CW-1:0]        rec_cnt;
    logic signed [SW-1:0] rec_sx, rec_sy;
    logic signed [QW-1:0] rec_sxx, rec_sxy;

    logic [CW-1:0]        r_n;
    logic signed [SW-1:0] r_sx, r_sy;
    logic signed [QW-1:0] r_sxx, r_sxy;

    logic [2:0]           r_op;
    logic signed [MW-1:0] op_a, op_b;
    logic [MW-1:0]        mag_a, mag_b;
    logic [PW-1:0]        r_ma, r_mp;
    logic [MW-1:0]        r_mb;
    logic                 r_mneg;
    logic [KW-1:0]        r_k;

    logic [NW-1:0] r_den, r_nb, r_na;
    logic [NW-1:0] prod, tgt, tgt_upd;

    logic          r_dsel;
    logic          r_qneg;
    logic [DW-1:0] r_dvd;
    logic [NW-1:0] r_rem, r_dabs;
    logic [NW-1:0] num, num_abs, den_abs;
    logic [NW:0]   trial, diff;
    logic          ge;

    logic [OutW-1:0] lim, qmag, qres;
    logic            sat;

    logic [OutW-1:0] r_slope, r_icpt;
    logic [1:0]      r_status;
    logic            r_sat;

    assign {rec_ovf, rec_cnt, rec_sx, rec_sy, rec_sxx, rec_sxy} = i_rec;

    assign o_q_ready        = r_state == S_IDLE;
    assign o_valid          = r_state == S_OUT;
    assign o_word.slope     = r_slope;
    assign o_word.intercept = r_icpt;
    assign o_word.status    = r_status;

    always_comb begin
        unique case (r_op)
            OpNSxx: begin
                op_a = MW'($signed({1'b0, r_n}));
                op_b = MW'(r_sxx);
            end
            OpSxSx: begin
                op_a = MW'(r_sx);
                op_b = MW'(r_sx);
            end
            OpNSxy: begin
                op_a = MW'($signed({1'b0, r_n}));
                op_b = MW'(r_sxy);
            end
            OpSxSy: begin
                op_a = MW'(r_sx);
                op_b = MW'(r_sy);
            end
            OpSySxx: begin
                op_a = MW'(r_sy);
                op_b = MW'(r_sxx);
            end
            OpSxSxy: begin
                op_a = MW'(r_sx);
                op_b = MW'(r_sxy);
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
        mag_a = op_a[MW-1] ? -op_a : op_a;
        mag_b = op_b[MW-1] ? -op_b : op_b;
    end

    always_comb begin
        prod = r_mneg ? -NW'(r_mp) : NW'(r_mp);
        case (r_op[2:1])
            2'd0:    tgt = r_den;
            2'd1:    tgt = r_nb;
            default: tgt = r_na;
        endcase
        tgt_upd = r_op[0] ? tgt - prod : tgt + prod;
    end

    always_comb begin
        num     = r_dsel ? r_na : r_nb;
        num_abs = num[NW-1] ? -num : num;
        den_abs = r_den[NW-1] ? -r_den : r_den;
        trial   = {r_rem, r_dvd[DW-1]};
        diff    = trial - {1'b0, r_dabs};
        ge      = trial >= {1'b0, r_dabs};
        lim     = r_qneg ? {1'b1, {(OutW-1){1'b0}}} : {1'b0, {(OutW-1){1'b1}}};
        sat     = r_dvd > DW'(lim);
        qmag    = sat ? lim : r_dvd[OutW-1:0];
        qres    = r_qneg ? -qmag : qmag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_dfin  <= 1'b0;
        end else begin
            r_dfin <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_state <= rec_ovf ? S_OUT : S_MLD;
                    end
                end
                S_MLD: begin
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    if (r_k == KW'(1)) begin
                        r_state <= S_MACC;
                    end
                end
                S_MACC: begin
                    if (r_op == OpSxSxy) begin
                        r_state <= (r_den == '0) ? S_OUT : S_DLD;
                    end else begin
                        r_state <= S_MLD;
                    end
                end
                S_DLD: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_dfin) begin
                        r_state <= r_dsel ? S_OUT : S_DLD;
                    end else if (r_k == KW'(1)) begin
                        r_dfin <= 1'b1;
                    end
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_n    <= rec_cnt;
                r_sx   <= rec_sx;
                r_sy   <= rec_sy;
                r_sxx  <= rec_sxx;
                r_sxy  <= rec_sxy;
                r_den  <= '0;
                r_nb   <= '0;
                r_na   <= '0;
                r_op   <= OpNSxx;
                r_dsel <= 1'b0;
                r_sat  <= 1'b0;
                if (i_q_valid && rec_ovf) begin
                    r_slope  <= '0;
                    r_icpt   <= '0;
                    r_status <= StTooMany;
                end
            end
            S_MLD: begin
                r_ma   <= PW'(mag_a);
                r_mb   <= mag_b;
                r_mp   <= '0;
                r_mneg <= op_a[MW-1] ^ op_b[MW-1];
                r_k    <= KW'(MW);
            end
            S_MUL: begin
                if (r_mb[0]) begin
                    r_mp <= r_mp + r_ma;
                end
                r_ma <= r_ma << 1;
                r_mb <= r_mb >> 1;
                r_k  <= r_k - KW'(1);
            end
            S_MACC: begin
                case (r_op[2:1])
                    2'd0:    r_den <= tgt_upd;
                    2'd1:    r_nb  <= tgt_upd;
                    default: r_na  <= tgt_upd;
                endcase
                r_op <= r_op + 3'd1;
                if (r_op == OpSxSxy && r_den == '0) begin
                    r_slope  <= '0;
                    r_icpt   <= '0;
                    r_status <= StZeroDen;
                end
            end
            S_DLD: begin
                r_dvd  <= {num_abs, {FracBits{1'b0}}};
                r_rem  <= '0;
                r_dabs <= den_abs;
                r_qneg <= num[NW-1] ^ r_den[NW-1];
                r_k    <= KW'(DW);
            end
            S_DIV: begin
                if (r_dfin) begin
                    if (r_dsel) begin
                        r_icpt   <= qres;
                        r_status <= (r_sat || sat) ? StSat : StOk;
                    end else begin
                        r_slope <= qres;
                    end
                    r_sat  <= r_sat | sat;
                    r_dsel <= 1'b1;
                end else begin
                    r_rem <= ge ? diff[NW-1:0] : trial[NW-1:0];
                    r_dvd <= {r_dvd[DW-2:0], ge};
                    r_k   <= r_k - KW'(1);
                end
            end
            S_OUT: begin
            end
            default: begin
            end
        endcase
    end

endmodule

[sv/least_squares_line_fit_top.sv]
// Least-squares line fit over a stream of (x, y) sample words.
// The input channel (i_in_valid, o_in_ready, i_in_word) takes one sample pair
// per word; the low SAMPLE_BITS bits of each field are read as signed values.
// Accumulation of count, sum x, sum y, sum x*x and sum x*y runs at one word
// per cycle in a two-stage front end, unless a closing word waits for the queue.
// A word with last set closes the data set and hands a snapshot of the sums
// to a two-entry queue, after which the sums clear and the next set starts.
// The back end computes the fit with one shift-add multiplier and one
// restoring divider, each retiring one bit per cycle. The multiplier works on
// M = 2*SAMPLE_BITS + clog2(MAX_SAMPLES+1) bit operands and the divider on a
// D = 2*M + 17 bit dividend.
// The front end keeps taking words while fits are in progress and stalls
// only when the queue already holds two finished data sets.
// The result word (slope, intercept, status) is held on o_out_word with
// o_out_valid high until i_out_ready takes it; the back end waits meanwhile.
// Synchronous active-low reset clears all sums and empties the queue.
module least_squares_line_fit_top #(
    parameter int MAX_SAMPLES = lsf_pkg::DefMaxSamples,
    parameter int SAMPLE_BITS = lsf_pkg::DefSampleBits
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  lsf_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output lsf_pkg::t_out_word o_out_word
);
    import lsf_pkg::*;

    localparam int RW = rec_w(MAX_SAMPLES, SAMPLE_BITS);

    logic          fq_valid, fq_ready;
    logic [RW-1:0] fq_rec;
    logic          qb_valid, qb_ready;
    logic [RW-1:0] qb_rec;

    lsf_front #(
        .MAX_SAMPLES(MAX_SAMPLES),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_word    (i_in_word),
        .o_q_valid (fq_valid),
        .i_q_ready (fq_ready),
        .o_rec     (fq_rec)
    );

    lsf_queue #(
        .W(RW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fq_valid),
        .o_ready (fq_ready),
        .i_data  (fq_rec),
        .o_valid (qb_valid),
        .i_ready (qb_ready),
        .o_data  (qb_rec)
    );

    lsf_back #(
        .MAX_SAMPLES(MAX_SAMPLES),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (qb_valid),
        .o_q_ready (qb_ready),
        .i_rec     (qb_rec),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_word    (o_out_word)
    );

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
    import lsf_pkg::*;

    localparam int MaxSamples = DefMaxSamples;
    localparam longint RunLimit = 6000000;
    localparam logic signed [127:0] PosLimit = 128'sh7FFF_FFFF_FFFF;
    localparam logic signed [127:0] NegLimit = -128'sh8000_0000_0000;

    class line_fit_board;
        int                  n_pairs;
        bit                  too_many;
        logic signed [127:0] sx, sy, sxx, sxy;
        t_out_word           fits_due[$];
        int                  errors;

        function new();
            errors = 0;
            clear_sums();
        endfunction

        function void clear_sums();
            n_pairs = 0;
            too_many = 0;
            sx = 0;
            sy = 0;
            sxx = 0;
            sxy = 0;
        endfunction

        function logic signed [47:0] scaled_quotient(logic signed [127:0] num,
                                                     logic signed [127:0] den,
                                                     ref bit sat);
            logic signed [127:0] q;
            q = (num <<< FracBits) / den;
            if (q > PosLimit) begin
                sat = 1;
                q = PosLimit;
            end else if (q < NegLimit) begin
                sat = 1;
                q = NegLimit;
            end
            return q[47:0];
        endfunction

        function void note_word(t_in_word w);
            logic signed [127:0] x, y, n, den;
            t_out_word fit;
            bit sat;
            x = 128'(w.x_value);
            y = 128'(w.y_value);
            sat = 0;
            if (n_pairs >= MaxSamples) begin
                too_many = 1;
            end else begin
                n_pairs++;
                sx += x;
                sy += y;
                sxx += x * x;
                sxy += x * y;
            end
            if (!w.last) return;
            fit.slope = '0;
            fit.intercept = '0;
            n = 128'(n_pairs);
            den = n * sxx - sx * sx;
            if (too_many) begin
                fit.status = StTooMany;
            end else if (den == 0) begin
                fit.status = StZeroDen;
            end else begin
                fit.slope = scaled_quotient(n * sxy - sx * sy, den, sat);
                fit.intercept = scaled_quotient(sy * sxx - sx * sxy, den, sat);
                fit.status = sat ? StSat : StOk;
            end
            fits_due.push_back(fit);
            clear_sums();
        endfunction

        function void check_fit(t_out_word got);
            t_out_word want;
            if (fits_due.size() == 0) begin
                $error("unexpected result word: slope %0d intercept %0d status %0d",
                       got.slope, got.intercept, got.status);
                errors++;
                return;
            end
            want = fits_due.pop_front();
            if (got.slope !== want.slope) begin
                $error("slope: expected %0d, actual %0d", want.slope, got.slope);
                errors++;
            end
            if (got.intercept !== want.intercept) begin
                $error("intercept: expected %0d, actual %0d", want.intercept, got.intercept);
                errors++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic       i_clk = 0;
    logic       i_rst_n = 0;
    logic       in_valid = 0;
    logic       out_ready = 0;
    t_in_word   in_word = '0;
    logic       in_ready, out_valid;
    t_out_word  out_word;
    longint     cycles = 0;
    int         results_taken = 0;
    line_fit_board board = new();

    least_squares_line_fit_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_word  (in_word),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_word (out_word)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= RunLimit) begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && out_ready) begin
            board.check_fit(out_word);
            results_taken++;
        end
    end

    task automatic send_pair(logic signed [15:0] x, logic signed [15:0] y, bit last);
        int gap;
        t_in_word w;
        gap = $urandom_range(0, 5);
        if ($urandom_range(0, 3) == 0) gap = 0;
        w.x_value = x;
        w.y_value = y;
        w.last = last;
        if (gap > 0) begin
            in_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1;
        in_word <= w;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        board.note_word(w);
    endtask

    task automatic send_random_set(int len, int spread);
        int i;
        logic signed [15:0] x0;
        x0 = 16'($urandom);
        for (i = 0; i < len; i++) begin
            if (spread == 0)
                send_pair(x0, 16'($urandom), i == len - 1);
            else if (spread < 65536)
                send_pair(16'(x0 + 16'($urandom_range(0, spread))), 16'($urandom),
                          i == len - 1);
            else
                send_pair(16'($urandom), 16'($urandom), i == len - 1);
        end
    endtask

    initial begin : receiver
        int k;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            k = $urandom_range(0, 5);
            if ($urandom_range(0, 2) == 0) k = 0;
            if (results_taken == 20) k = 4000;
            if (k > 0) begin
                out_ready <= 0;
                repeat (k) @(posedge i_clk);
            end
            out_ready <= 1;
            @(posedge i_clk);
            while (!out_valid) @(posedge i_clk);
        end
    end

    initial begin : stimulus
        int sent, len, spread, i;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        send_pair(16'sh7FFF, 16'sh7FFF, 0);
        send_pair(-16'sh8000, -16'sh8000, 0);
        send_pair(16'sh0000, 16'sh7FFF, 1);
        send_pair(16'sh1234, -16'sh8000, 1);
        send_pair(16'sh0055, 16'sh0001, 0);
        send_pair(16'sh0055, -16'sh0002, 0);
        send_pair(16'sh0055, 16'sh0300, 1);
        send_pair(16'sh7FFF, 16'sh7FFF, 0);
        send_pair(16'sh7FFE, -16'sh8000, 1);
        send_pair(-16'sh8000, 16'sh7FFF, 0);
        send_pair(-16'sh7FFF, -16'sh8000, 1);
        send_pair(16'sh0001, 16'sh0002, 0);
        send_pair(16'sh0002, 16'sh0004, 0);
        send_pair(16'sh0003, 16'sh0006, 1);
        send_pair(-16'sh8000, -16'sh8000, 0);
        send_pair(16'sh7FFF, 16'sh7FFF, 1);

        for (i = 0; i < MaxSamples + 3; i++)
            send_pair(16'($urandom), 16'($urandom), i == MaxSamples + 2);
        for (i = 0; i < MaxSamples; i++)
            send_pair(16'($urandom), 16'($urandom), i == MaxSamples - 1);

        sent = 0;
        while (sent < 240) begin
            len = $urandom_range(2, 12);
            if ($urandom_range(0, 9) == 0) len = 1;
            case ($urandom_range(0, 9))
                0: spread = 0;
                1: spread = $urandom_range(1, 3);
                default: spread = 65536;
            endcase
            send_random_set(len, spread);
            sent += len;
        end
        in_valid <= 0;

        while (board.fits_due.size() != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
        if (board.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
